// ===== sv/brd_pkg.sv =====
// ----------------------------------------------------------------------------
// brd_pkg
// Shared constants and register codes for the binary rectangular dilation unit.
// ----------------------------------------------------------------------------
package brd_pkg;

  // default limits handed to the top level parameters
  localparam int BRD_MAX_WIDTH  = 1024;
  localparam int BRD_MAX_HEIGHT = 4096;
  localparam int BRD_MAX_HALF_X = 15;
  localparam int BRD_MAX_HALF_Y = 15;

  // payload and register field widths
  localparam int PIXEL_W = 8;
  localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'hFF;
  localparam int HALF_W = 4;
  localparam int IMG_W_W = 11;
  localparam int IMG_H_W = 13;

  // configuration port
  localparam int REG_INDEX_W = 3;
  localparam int REG_DATA_W = 13;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_BLOB_WHITE   = 3'd0,
    REG_HALF_WIDTH   = 3'd1,
    REG_HALF_HEIGHT  = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4
  } reg_index_t;

  // register reset values
  localparam logic RST_BLOB_WHITE = 1'b1;
  localparam logic [HALF_W-1:0] RST_HALF_WIDTH = 4'd1;
  localparam logic [HALF_W-1:0] RST_HALF_HEIGHT = 4'd1;
  localparam logic [IMG_W_W-1:0] RST_IMAGE_WIDTH = 11'd1024;
  localparam logic [IMG_H_W-1:0] RST_IMAGE_HEIGHT = 13'd1024;

endpackage

// ===== sv/brd_if.sv =====
// ----------------------------------------------------------------------------
// brd_in_if / brd_out_if
// Valid/ready stream channels for source pixels and dilated results.
// ----------------------------------------------------------------------------
interface brd_in_if
  import brd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output operation, output pixel, input ready);
  modport sink (input valid, input operation, input pixel, output ready);
endinterface

interface brd_out_if
  import brd_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] out_pixel;
  logic               last_of_run;

  modport source (output valid, output out_pixel, output last_of_run, input ready);
  modport sink (input valid, input out_pixel, input last_of_run, output ready);
endinterface

// ===== sv/binary_rect_dilation_unit.sv =====
// ----------------------------------------------------------------------------
// binary_rect_dilation_unit
// Separable binary dilation over a raster stream: a row gap counter does the
// horizontal pass, a column gap memory with read-modify-write the vertical one.
// ----------------------------------------------------------------------------
// Pipeline: a result passes the stage register st1, then the output register.
// Throughput: one item per cycle unless the output stalls; the last pixel of a
//   row updates min(half_width, column) + 1 column gaps (up to MAX_HALF_X + 1)
//   in a burst that holds off input, through the single read-modify-write path.
// Reset: synchronous, restores registers and frame position; the column gap
//   memory is not cleared, the first row of each frame reads it as saturated.
module binary_rect_dilation_unit
  import brd_pkg::*;
#(
  parameter int MAX_WIDTH  = BRD_MAX_WIDTH,
  parameter int MAX_HEIGHT = BRD_MAX_HEIGHT,
  parameter int MAX_HALF_X = BRD_MAX_HALF_X,
  parameter int MAX_HALF_Y = BRD_MAX_HALF_Y
) (
  input  logic                   clk,
  input  logic                   rst,
  brd_in_if.sink                 pixels,
  brd_out_if.source              results,
  input  logic                   write_enable,
  input  logic [REG_INDEX_W-1:0] register_index,
  input  logic [REG_DATA_W-1:0]  write_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CW1 = CW + 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int XW  = (WW > IMG_W_W) ? WW : IMG_W_W;
  localparam int HTW = $clog2(MAX_HEIGHT + 1);
  localparam int YW  = (HTW > IMG_H_W) ? HTW : IMG_H_W;
  localparam int RW  = $clog2(MAX_HEIGHT + MAX_HALF_Y);
  localparam int RX  = RW + 1;
  localparam int HXW = $clog2(MAX_HALF_X + 1);
  localparam int HYW = $clog2(MAX_HALF_Y + 1);
  localparam int HXC = (HXW > HALF_W) ? HXW : HALF_W;
  localparam int HYC = (HYW > HALF_W) ? HYW : HALF_W;
  localparam int LW  = ((CW > HXW) ? CW : HXW) + 1;
  localparam int GAP_SAT = 2 * MAX_HALF_X + 2 * MAX_HALF_Y + 1;
  localparam int GW  = $clog2(GAP_SAT + 1);
  localparam int DW  = $clog2(GAP_SAT + MAX_HALF_X + 1);

  typedef struct packed {
    logic          valid;
    logic [CW-1:0] hcol;
    logic          hval;
    logic          emit;
    logic          first;
    logic          last;
  } op_t;

  function automatic logic [GW-1:0] sat_inc(input logic [GW-1:0] g);
    if (g >= GW'(GAP_SAT)) begin
      return GW'(GAP_SAT);
    end
    return g + 1'b1;
  endfunction

  // configuration registers
  logic                 blob_white;
  logic [HALF_W-1:0]    half_width;
  logic [HALF_W-1:0]    half_height;
  logic [IMG_W_W-1:0]   image_width;
  logic [IMG_H_W-1:0]   image_height;
  logic                 cfg_hit;

  always_comb begin
    case (register_index)
      REG_BLOB_WHITE, REG_HALF_WIDTH, REG_HALF_HEIGHT,
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: cfg_hit = write_enable;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blob_white   <= RST_BLOB_WHITE;
      half_width   <= RST_HALF_WIDTH;
      half_height  <= RST_HALF_HEIGHT;
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
    end else if (write_enable) begin
      case (register_index)
        REG_BLOB_WHITE:   blob_white   <= write_data[0];
        REG_HALF_WIDTH:   half_width   <= write_data[HALF_W-1:0];
        REG_HALF_HEIGHT:  half_height  <= write_data[HALF_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= write_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= write_data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [WW-1:0]      eff_w;
  logic [HTW-1:0]     eff_h;
  logic [HXW-1:0]     hw;
  logic [HYW-1:0]     hh;
  logic [PIXEL_W-1:0] blob;
  logic [PIXEL_W-1:0] bg;
  logic [CW-1:0]      w_last;

  always_comb begin
    if (image_width == '0) begin
      eff_w = WW'(1);
    end else if (XW'(image_width) > XW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
    if (image_height == '0) begin
      eff_h = HTW'(1);
    end else if (YW'(image_height) > YW'(MAX_HEIGHT)) begin
      eff_h = HTW'(MAX_HEIGHT);
    end else begin
      eff_h = HTW'(image_height);
    end
    if (HXC'(half_width) > HXC'(MAX_HALF_X)) begin
      hw = HXW'(MAX_HALF_X);
    end else begin
      hw = HXW'(half_width);
    end
    if (HYC'(half_height) > HYC'(MAX_HALF_Y)) begin
      hh = HYW'(MAX_HALF_Y);
    end else begin
      hh = HYW'(half_height);
    end
  end

  assign blob   = blob_white ? PIXEL_MAX : '0;
  assign bg     = ~blob;
  assign w_last = CW'(eff_w - 1'b1);

  // frame position and horizontal pass
  logic [CW-1:0] in_column;
  logic [RW-1:0] in_row;
  logic [GW-1:0] row_gap;

  // row end burst
  logic          burst_active;
  logic [CW-1:0] burst_hcol;
  logic [DW-1:0] burst_dist;
  logic          burst_emit;
  logic          burst_first;

  logic          adv;
  logic          in_fire;
  logic          y_img;
  logic          ignore;
  logic          is_blob;
  logic          row_end;
  logic          c_ge_hw;
  logic          has_op;
  logic          more;
  logic          emit;
  logic          first;
  logic          frame_end;
  logic [GW-1:0] rg_new;
  logic [CW-1:0] lo;
  logic [DW-1:0] d0;
  logic [DW-1:0] dist0;
  logic [DW-1:0] s_dist;
  op_t           s_op;

  assign adv          = !results.valid || results.ready;
  assign pixels.ready = adv && !burst_active;
  assign in_fire      = pixels.valid && pixels.ready;

  always_comb begin
    y_img   = RX'(in_row) < RX'(eff_h);
    ignore  = y_img && pixels.operation;   // early flush does nothing
    is_blob = y_img && (pixels.pixel == blob);
    row_end = (in_column == w_last);
    c_ge_hw = LW'(in_column) >= LW'(hw);
    if (is_blob) begin
      rg_new = '0;
    end else if (in_column == '0) begin
      rg_new = GW'(GAP_SAT);
    end else begin
      rg_new = sat_inc(row_gap);
    end
    lo    = c_ge_hw ? CW'(LW'(in_column) - LW'(hw)) : '0;
    d0    = c_ge_hw ? '0 : DW'(LW'(hw) - LW'(in_column));
    dist0 = DW'(rg_new) + d0;
    has_op = row_end || c_ge_hw;
    more   = row_end && (lo != w_last);
    emit   = RX'(in_row) >= RX'(hh);
    first  = (in_row == '0);
    frame_end = (RX'(in_row) + 1'b1) >= (RX'(eff_h) + RX'(hh));

    if (burst_active) begin
      s_op.valid = 1'b1;
      s_op.hcol  = burst_hcol;
      s_op.emit  = burst_emit;
      s_op.first = burst_first;
      s_op.last  = (burst_hcol == w_last);
      s_dist     = burst_dist;
    end else begin
      s_op.valid = pixels.valid && !ignore && has_op;
      s_op.hcol  = lo;
      s_op.emit  = emit;
      s_op.first = first;
      s_op.last  = !more;
      s_dist     = dist0;
    end
    // horizontal window at hcol holds a blob
    s_op.hval = s_dist <= (DW'(hw) << 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_active <= 1'b0;
      in_column    <= '0;
      in_row       <= '0;
      row_gap      <= GW'(GAP_SAT);
    end else if (cfg_hit) begin
      burst_active <= 1'b0;
      in_column    <= '0;
      in_row       <= '0;
      row_gap      <= GW'(GAP_SAT);
    end else begin
      if (burst_active && adv) begin
        burst_hcol <= burst_hcol + 1'b1;
        burst_dist <= burst_dist + 1'b1;
        if (burst_hcol == w_last) begin
          burst_active <= 1'b0;
        end
      end
      if (in_fire && !ignore) begin
        row_gap <= rg_new;
        if (row_end) begin
          in_column <= '0;
          in_row    <= frame_end ? '0 : in_row + 1'b1;
        end else begin
          in_column <= in_column + 1'b1;
        end
        if (more) begin
          burst_active <= 1'b1;
          burst_hcol   <= lo + 1'b1;
          burst_dist   <= dist0 + 1'b1;
          burst_emit   <= emit;
          burst_first  <= first;
        end
      end
    end
  end

  // column gap memory, read-modify-write with forwarding of the write in flight
  logic [GW-1:0]      col_mem [MAX_WIDTH];
  logic [GW-1:0]      rd_data;
  logic [GW-1:0]      fwd;
  logic               byp;
  logic [GW-1:0]      old_gap;
  logic [GW-1:0]      g1;
  op_t                st1;
  logic               out_valid;
  logic [PIXEL_W-1:0] out_pixel;
  logic               out_last;

  always_comb begin
    if (st1.first) begin
      old_gap = GW'(GAP_SAT);     // first row of a frame sees no blob above
    end else if (byp) begin
      old_gap = fwd;
    end else begin
      old_gap = rd_data;
    end
    g1 = st1.hval ? '0 : sat_inc(old_gap);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (st1.valid) begin
        col_mem[st1.hcol] <= g1;
      end
      rd_data <= col_mem[s_op.hcol];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1.valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      st1       <= s_op;
      byp       <= st1.valid && (s_op.hcol == st1.hcol);
      fwd       <= g1;
      out_valid <= st1.valid && st1.emit;
      out_pixel <= (g1 <= (GW'(hh) << 1)) ? blob : bg;
      out_last  <= st1.last;
    end
  end

  assign results.valid       = out_valid;
  assign results.out_pixel   = out_pixel;
  assign results.last_of_run = out_last;

  a_column_in_row: assert property (@(posedge clk) disable iff (rst)
    CW1'(in_column) < CW1'(eff_w))
    else $error("input column beyond image width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    RX'(in_row) < (RX'(eff_h) + RX'(hh)))
    else $error("input row beyond drain rows");

  a_burst_range: assert property (@(posedge clk) disable iff (rst)
    burst_active |-> (burst_hcol != '0) && (CW1'(burst_hcol) < CW1'(eff_w)))
    else $error("row end burst column out of range");

  a_burst_blocks_input: assert property (@(posedge clk) disable iff (rst)
    burst_active && adv && (burst_hcol != w_last) |=> burst_active)
    else $error("row end burst stopped early");

endmodule

// ===== dv/brd_dilation_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// brd_dilation_tb_pkg
// Item codes shared by the dilation testbench top and its checker.
// ----------------------------------------------------------------------------
package brd_dilation_tb_pkg;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } brd_op_t;

endpackage

// ===== dv/brd_dilation_check.sv =====
// ----------------------------------------------------------------------------
// brd_dilation_check
// Watches the pixel, result and register ports of the dilation unit, keeps its
// own separable dilation state and compares every result item in order.
// ----------------------------------------------------------------------------
module brd_dilation_check
  import brd_pkg::*;
  import brd_dilation_tb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  brd_in_if                      pixels,
  brd_out_if                     results,
  input  logic                   write_enable,
  input  logic [REG_INDEX_W-1:0] register_index,
  input  logic [REG_DATA_W-1:0]  write_data,
  output int                     failures,
  output int                     pending
);

  localparam int unsigned GAP_SAT = 2 * BRD_MAX_HALF_X + 2 * BRD_MAX_HALF_Y + 1;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [PIXEL_W-1:0] out_pixel;
    logic               last_of_run;
  } dilated_t;

  logic               blob_white;
  logic [HALF_W-1:0]  half_width;
  logic [HALF_W-1:0]  half_height;
  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;

  int unsigned column_gap [BRD_MAX_WIDTH];
  int unsigned row_gap;
  int unsigned in_column;
  int unsigned in_row;

  dilated_t dilated_q[$];
  int mismatches = 0;
  int waiting = 0;

  assign failures = mismatches;
  assign pending = waiting;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("%0t: dilation mismatch: %s", $time, msg);
    end
  endtask

  function automatic int unsigned sat_inc(input int unsigned g);
    return (g >= GAP_SAT) ? GAP_SAT : g + 1;
  endfunction

  function void restart_frame();
    foreach (column_gap[i]) column_gap[i] = GAP_SAT;
    row_gap = GAP_SAT;
    in_column = 0;
    in_row = 0;
  endfunction

  function void apply_write(input logic [REG_INDEX_W-1:0] idx,
                            input logic [REG_DATA_W-1:0] data);
    case (idx)
      REG_BLOB_WHITE:   blob_white = data[0];
      REG_HALF_WIDTH:   half_width = data[HALF_W-1:0];
      REG_HALF_HEIGHT:  half_height = data[HALF_W-1:0];
      REG_IMAGE_WIDTH:  image_width = data[IMG_W_W-1:0];
      REG_IMAGE_HEIGHT: image_height = data[IMG_H_W-1:0];
      default:          return;
    endcase
    restart_frame();
  endfunction

  // one raster position: horizontal pass on the row gap, vertical pass on the
  // column gaps of the columns that are now complete
  function void dilate_item(input brd_op_t op, input logic [PIXEL_W-1:0] pix);
    int unsigned w, h, hw, hh, c, y, lo, col, d, g;
    logic [PIXEL_W-1:0] blob, bg;
    logic is_blob, row_end;
    int n;
    w = (image_width == 0) ? 1 : (image_width > BRD_MAX_WIDTH) ? BRD_MAX_WIDTH : image_width;
    h = (image_height == 0) ? 1 :
        (image_height > BRD_MAX_HEIGHT) ? BRD_MAX_HEIGHT : image_height;
    hw = (half_width > BRD_MAX_HALF_X) ? BRD_MAX_HALF_X : half_width;
    hh = (half_height > BRD_MAX_HALF_Y) ? BRD_MAX_HALF_Y : half_height;
    blob = blob_white ? PIXEL_MAX : '0;
    bg = ~blob;
    n = 0;
    if (in_column >= w) in_column = 0;
    c = in_column;
    y = in_row;
    if (y < h) begin
      // flush before the image is complete does nothing
      if (op == OP_FLUSH) return;
      is_blob = (pix == blob);
    end else begin
      is_blob = 1'b0;
    end
    if (c == 0) row_gap = GAP_SAT;
    row_gap = is_blob ? 0 : sat_inc(row_gap);
    row_end = (c + 1 == w);
    if (row_end) begin
      lo = (c >= hw) ? c - hw : 0;
    end else if (c >= hw) begin
      lo = c - hw;
    end else begin
      lo = w;
    end
    for (col = lo; col < w && (col + hw <= c || row_end); col++) begin
      d = col + hw - c;
      g = (row_gap + d <= 2 * hw) ? 0 : sat_inc(column_gap[col]);
      column_gap[col] = g;
      if (y >= hh) begin
        dilated_q.push_back(dilated_t'{out_pixel: (g <= 2 * hh) ? blob : bg,
                                       last_of_run: 1'b0});
        n++;
      end
    end
    if (n > 0) dilated_q[dilated_q.size() - 1].last_of_run = 1'b1;
    if (row_end) begin
      in_column = 0;
      if (y + 1 >= h + hh) begin
        restart_frame();
      end else begin
        in_row = y + 1;
      end
    end else begin
      in_column = c + 1;
    end
  endfunction

  always @(posedge clk) begin
    dilated_t want;
    if (rst) begin
      blob_white = RST_BLOB_WHITE;
      half_width = RST_HALF_WIDTH;
      half_height = RST_HALF_HEIGHT;
      image_width = RST_IMAGE_WIDTH;
      image_height = RST_IMAGE_HEIGHT;
      restart_frame();
      dilated_q.delete();
    end else begin
      if (write_enable) apply_write(register_index, write_data);
      if (pixels.valid && pixels.ready) begin
        dilate_item(brd_op_t'(pixels.operation), pixels.pixel);
      end
      if (results.valid && results.ready) begin
        if (dilated_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing waiting", results.out_pixel));
        end else begin
          want = dilated_q.pop_front();
          if (results.out_pixel !== want.out_pixel) begin
            report_mismatch($sformatf("out_pixel %h, wanted %h",
                                      results.out_pixel, want.out_pixel));
          end
          if (results.last_of_run !== want.last_of_run) begin
            report_mismatch($sformatf("last_of_run %b, wanted %b",
                                      results.last_of_run, want.last_of_run));
          end
        end
      end
    end
    waiting = dilated_q.size();
  end

endmodule

// ===== dv/tb_binary_rect_dilation_unit.sv =====
// ----------------------------------------------------------------------------
// tb_binary_rect_dilation_unit
// Drives raster frames, early and drain flushes and register changes into the
// dilation unit with random idling on both channels; the checker beside the
// block predicts each result item and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_binary_rect_dilation_unit;
  import brd_pkg::*;
  import brd_dilation_tb_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 140;

  logic                   clk;
  logic                   rst;
  logic                   write_enable;
  logic [REG_INDEX_W-1:0] register_index;
  logic [REG_DATA_W-1:0]  write_data;

  int failures;
  int pending;
  int cycle_count = 0;
  int items_sent = 0;
  bit steady = 1'b0;

  // frame shape as the block sees it, used to build well-formed frames
  logic [PIXEL_W-1:0] cur_blob = PIXEL_MAX;
  int cur_w = BRD_MAX_WIDTH;
  int cur_h = 1024;
  int cur_hh = 1;

  brd_in_if  pixels ();
  brd_out_if results ();

  binary_rect_dilation_unit dut (
    .clk            (clk),
    .rst            (rst),
    .pixels         (pixels),
    .results        (results),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data)
  );

  brd_dilation_check dilation_check (
    .clk            (clk),
    .rst            (rst),
    .pixels         (pixels),
    .results        (results),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .failures       (failures),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // result side back-pressure
  initial begin
    int hold;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (steady || $urandom_range(0, 2) != 0) begin
        results.ready <= 1'b1;
        hold = steady ? 1 : $urandom_range(1, 12);
      end else begin
        results.ready <= 1'b0;
        hold = pick_gap() + 1;
      end
      repeat (hold - 1) @(posedge clk);
    end
  end

  function automatic int clamp_size(input int v, input int limit);
    return (v < 1) ? 1 : (v > limit) ? limit : v;
  endfunction

  // random junk above the field so every data bit toggles
  function automatic logic [REG_DATA_W-1:0] with_noise(input int unsigned value,
                                                       input int field_w);
    logic [REG_DATA_W-1:0] junk;
    junk = REG_DATA_W'($urandom);
    return (junk << field_w) | REG_DATA_W'(value);
  endfunction

  function automatic logic [REG_DATA_W-1:0] random_setting(input reg_index_t idx);
    case (idx)
      REG_BLOB_WHITE:  return with_noise($urandom_range(0, 1), 1);
      REG_HALF_WIDTH:  return with_noise($urandom_range(0, 15), HALF_W);
      REG_HALF_HEIGHT: begin
        return with_noise(($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) :
                          $urandom_range(0, 3), HALF_W);
      end
      REG_IMAGE_WIDTH: return with_noise($urandom_range(0, 10), IMG_W_W);
      default:         return REG_DATA_W'($urandom_range(0, 6));
    endcase
  endfunction

  function automatic logic [PIXEL_W-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return cur_blob;
    if (r < 8) return ~cur_blob;
    return PIXEL_W'($urandom);
  endfunction

  // entered and left just after a rising edge
  task automatic write_reg(input logic [REG_INDEX_W-1:0] idx,
                           input logic [REG_DATA_W-1:0] data);
    write_enable <= 1'b1;
    register_index <= idx;
    write_data <= data;
    @(posedge clk);
    write_enable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_register(input reg_index_t idx, input logic [REG_DATA_W-1:0] data);
    write_reg(idx, data);
    case (idx)
      REG_BLOB_WHITE:   cur_blob = data[0] ? PIXEL_MAX : '0;
      REG_HALF_HEIGHT:  cur_hh = data[HALF_W-1:0];
      REG_IMAGE_WIDTH:  cur_w = clamp_size(data[IMG_W_W-1:0], BRD_MAX_WIDTH);
      REG_IMAGE_HEIGHT: cur_h = clamp_size(data[IMG_H_W-1:0], BRD_MAX_HEIGHT);
      default: ;
    endcase
  endtask

  task automatic program_all(input logic white, input int hw, input int hh,
                             input int w, input int h);
    set_register(REG_BLOB_WHITE, with_noise(white, 1));
    set_register(REG_HALF_WIDTH, with_noise(hw, HALF_W));
    set_register(REG_HALF_HEIGHT, with_noise(hh, HALF_W));
    set_register(REG_IMAGE_WIDTH, with_noise(w, IMG_W_W));
    set_register(REG_IMAGE_HEIGHT, REG_DATA_W'(h));
  endtask

  // wait until every predicted item is out and the row-end work has drained
  task automatic settle();
    pixels.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(input brd_op_t op, input logic [PIXEL_W-1:0] pix);
    int gap;
    logic taken;
    gap = pick_gap();
    if (gap > 0) begin
      pixels.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixels.valid <= 1'b1;
    pixels.operation <= op;
    pixels.pixel <= pix;
    do begin
      @(negedge clk);
      taken = pixels.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // raster positions first .. first+count-1 of the current frame
  task automatic send_frame(input int first, input int count);
    int p;
    for (p = first; p < first + count; p++) begin
      if (p / cur_w < cur_h) begin
        if ($urandom_range(0, 9) == 0) send_item(OP_FLUSH, PIXEL_W'($urandom));
        send_item(OP_PIXEL, pick_pixel());
      end else if ($urandom_range(0, 4) == 0) begin
        send_item(OP_PIXEL, PIXEL_W'($urandom));
      end else begin
        send_item(OP_FLUSH, PIXEL_W'($urandom));
      end
      items_sent++;
    end
  endtask

  initial begin
    int total, frames;
    reg_index_t ridx;
    rst <= 1'b1;
    write_enable <= 1'b0;
    register_index <= '0;
    write_data <= '0;
    pixels.valid <= 1'b0;
    pixels.operation <= OP_PIXEL;
    pixels.pixel <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset width and reach, no vertical reach so rows come out at once
    set_register(REG_HALF_HEIGHT, '0);
    send_item(OP_FLUSH, 8'h5A);
    send_item(OP_PIXEL, PIXEL_MAX);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_PIXEL, 8'h01);
    send_item(OP_PIXEL, 8'hFE);
    send_item(OP_PIXEL, 8'h80);
    send_item(OP_PIXEL, 8'h7F);
    settle();

    // zero sizes clamp to one pixel, full reach: all output comes in the drain
    program_all(1'b0, 15, 15, 0, 0);
    send_frame(0, 8);
    settle();
    // writes past the register list leave the frame running
    for (int i = int'(REG_IMAGE_HEIGHT) + 1; i < (1 << REG_INDEX_W); i++) begin
      write_reg(REG_INDEX_W'(i), REG_DATA_W'($urandom));
    end
    send_frame(8, 8);
    settle();

    // widest row, width register beyond the limit, cut short
    program_all(1'($urandom_range(0, 1)), 15, 0, (1 << IMG_W_W) - 1, 1);
    send_frame(0, 40);
    settle();

    // tallest height, cut short
    program_all(1'($urandom_range(0, 1)), $urandom_range(0, 15), 2, 4,
                (1 << IMG_H_W) - 1);
    send_frame(0, 30);
    settle();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      if (items_sent > 0 && $urandom_range(0, 3) == 0) begin
        ridx = reg_index_t'($urandom_range(0, 4));
        set_register(ridx, random_setting(ridx));
      end else begin
        for (int i = 0; i <= int'(REG_IMAGE_HEIGHT); i++) begin
          set_register(reg_index_t'(i), random_setting(reg_index_t'(i)));
        end
      end
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        total = cur_w * (cur_h + cur_hh);
        if ($urandom_range(0, 5) == 0) begin
          // broken frame, the next register write restarts it
          send_frame(0, $urandom_range(1, total));
          break;
        end
        send_frame(0, total);
      end
      settle();
    end
    steady = 1'b0;

    settle();
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
